// ----- rtl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants and types for the swept box collision time unit.
// ----------------------------------------------------------------------------
package sac_pkg;

    // Default coordinate width (signed Q12.4) and time fraction bits
    localparam int CoordWidthDef = 16;
    localparam int TimeFracDef   = 15;

    // Fixed result field widths
    localparam int EntryWidth  = 16;
    localparam int NormalWidth = 2;

    // Normal codes
    localparam logic signed [NormalWidth-1:0] NormalPos  = 2'sb01;
    localparam logic signed [NormalWidth-1:0] NormalNeg  = 2'sb11;
    localparam logic signed [NormalWidth-1:0] NormalZero = 2'sb00;

    // Per-item side flags that travel beside the dividers
    typedef struct packed {
        logic vel_x_zero;
        logic vel_y_zero;
        logic gap_x_neg;   // x entry gap below zero
        logic gap_y_neg;   // y entry gap below zero
    } aux_t;

endpackage

// ----- rtl/swept_aabb_collision_time_unit.sv -----
// ----------------------------------------------------------------------------
// swept_aabb_collision_time_unit
// Swept box against still box: entry time, hit flag and surface normal.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one box pair per transfer (mover position, size and
//   displacement, obstacle position and size); m_axis returns one result
//   per pair, in order: hit, entry time (Q1.TIME_FRAC_BITS) and normal.
//   The datapath is TIME_FRAC_BITS+6 register stages: a gap stage, a divider
//   set-up stage, one stage per quotient bit (TIME_FRAC_BITS+2 of them) in
//   four parallel divider lanes, a rounding stage and the output register.
//   One pair is taken every cycle unless the pipeline is full and held;
//   a new pair may enter before the last one has left.
//   Each stage holds when the stage after it is full and held, so empty
//   stages fill while the receiver stalls; s_axis_tready falls only once
//   every stage holds an item. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties every stage; payload registers
//   keep stale data that is never shown.
// ----------------------------------------------------------------------------
module swept_aabb_collision_time_unit #(
    parameter int COORD_WIDTH    = sac_pkg::CoordWidthDef,
    parameter int TIME_FRAC_BITS = sac_pkg::TimeFracDef
) (
    input  logic aclk,
    input  logic aresetn,
    // mover_left, mover_top, mover_width, mover_height, vel_x, vel_y,
    // obstacle_left, obstacle_top, obstacle_width, obstacle_height
    input  logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // hit, entry_time, normal_x, normal_y
    output logic [23:0] m_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready
);
    localparam int CW = COORD_WIDTH;
    localparam int T  = TIME_FRAC_BITS;
    localparam int SW = CW - 1;
    localparam int GW = CW + 2;
    localparam int TW = T + 3;
    localparam int K  = T + 2;
    localparam int N  = K + 4;               // register stages
    localparam int EW = sac_pkg::EntryWidth;
    localparam int NW = sac_pkg::NormalWidth;

    // Field offsets in s_axis_tdata
    localparam int OffMt = CW;
    localparam int OffMw = 2 * CW;
    localparam int OffMh = 2 * CW + SW;
    localparam int OffVx = 2 * CW + 2 * SW;
    localparam int OffVy = 3 * CW + 2 * SW;
    localparam int OffOl = 4 * CW + 2 * SW;
    localparam int OffOt = 5 * CW + 2 * SW;
    localparam int OffOw = 6 * CW + 2 * SW;
    localparam int OffOh = 6 * CW + 3 * SW;

    logic signed [CW-1:0] mover_left, mover_top, vel_x, vel_y, obstacle_left, obstacle_top;
    logic [SW-1:0] mover_width, mover_height, obstacle_width, obstacle_height;

    assign mover_left      = s_axis_tdata[CW-1:0];
    assign mover_top       = s_axis_tdata[OffMt +: CW];
    assign mover_width     = s_axis_tdata[OffMw +: SW];
    assign mover_height    = s_axis_tdata[OffMh +: SW];
    assign vel_x           = s_axis_tdata[OffVx +: CW];
    assign vel_y           = s_axis_tdata[OffVy +: CW];
    assign obstacle_left   = s_axis_tdata[OffOl +: CW];
    assign obstacle_top    = s_axis_tdata[OffOt +: CW];
    assign obstacle_width  = s_axis_tdata[OffOw +: SW];
    assign obstacle_height = s_axis_tdata[OffOh +: SW];

    // Stage valids and load enables: a stage loads when empty or draining
    logic [N-1:0] vld_reg;
    logic [N:0]   ld;

    always_comb begin
        ld[N] = m_axis_tready;
        for (int i = N - 1; i >= 0; i--) begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end
    assign s_axis_tready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < N; i++) begin
                if (ld[i]) begin
                    vld_reg[i] <= (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Gap stage
    logic signed [GW-1:0] gxi, gxo, gyi, gyo;
    logic signed [GW-1:0] gxi_reg, gxo_reg, gyi_reg, gyo_reg;
    logic signed [CW-1:0] vx_reg, vy_reg;
    sac_pkg::aux_t aux_next;
    sac_pkg::aux_t aux_reg [0:K+2];

    sac_gap #(.CW(CW)) u_gap_x (
        .pos(mover_left), .size(mover_width), .vel(vel_x),
        .opos(obstacle_left), .osize(obstacle_width),
        .gap_in(gxi), .gap_out(gxo)
    );
    sac_gap #(.CW(CW)) u_gap_y (
        .pos(mover_top), .size(mover_height), .vel(vel_y),
        .opos(obstacle_top), .osize(obstacle_height),
        .gap_in(gyi), .gap_out(gyo)
    );

    always_comb begin
        aux_next.vel_x_zero = vel_x == '0;
        aux_next.vel_y_zero = vel_y == '0;
        aux_next.gap_x_neg  = gxi[GW-1];
        aux_next.gap_y_neg  = gyi[GW-1];
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            gxi_reg    <= gxi;
            gxo_reg    <= gxo;
            gyi_reg    <= gyi;
            gyo_reg    <= gyo;
            vx_reg     <= vel_x;
            vy_reg     <= vel_y;
            aux_reg[0] <= aux_next;
        end
        // Carry side flags beside the dividers
        for (int i = 1; i <= K + 2; i++) begin
            if (ld[i]) begin
                aux_reg[i] <= aux_reg[i-1];
            end
        end
    end

    // Four divider lanes
    logic signed [TW-1:0] tx_in, tx_out, ty_in, ty_out;

    sac_div_lane #(.CW(CW), .TFB(T)) u_div_xi (
        .aclk(aclk), .ld(ld[K+2:1]), .gap(gxi_reg), .vel(vx_reg), .quot(tx_in));
    sac_div_lane #(.CW(CW), .TFB(T)) u_div_xo (
        .aclk(aclk), .ld(ld[K+2:1]), .gap(gxo_reg), .vel(vx_reg), .quot(tx_out));
    sac_div_lane #(.CW(CW), .TFB(T)) u_div_yi (
        .aclk(aclk), .ld(ld[K+2:1]), .gap(gyi_reg), .vel(vy_reg), .quot(ty_in));
    sac_div_lane #(.CW(CW), .TFB(T)) u_div_yo (
        .aclk(aclk), .ld(ld[K+2:1]), .gap(gyo_reg), .vel(vy_reg), .quot(ty_out));

    // Decide and register the result
    logic                 hit;
    logic [EW-1:0]        entry_time;
    logic signed [NW-1:0] normal_x, normal_y;
    logic [23:0]          out_reg;

    sac_resolve #(.TFB(T)) u_resolve (
        .tx_in(tx_in), .tx_out(tx_out), .ty_in(ty_in), .ty_out(ty_out),
        .aux(aux_reg[K+2]), .hit(hit), .entry_time(entry_time),
        .normal_x(normal_x), .normal_y(normal_y)
    );

    always_ff @(posedge aclk) begin
        if (ld[N-1]) begin
            out_reg <= {3'b000, normal_y, normal_x, entry_time, hit};
        end
    end

    assign m_axis_tdata  = out_reg;
    assign m_axis_tvalid = vld_reg[N-1];
endmodule

// ----- rtl/sac_gap.sv -----
// ----------------------------------------------------------------------------
// sac_gap
// Near and far gaps of one axis, chosen by the direction of travel.
// ----------------------------------------------------------------------------
module sac_gap #(
    parameter int CW = sac_pkg::CoordWidthDef
) (
    input  logic signed [CW-1:0] pos,
    input  logic        [CW-2:0] size,
    input  logic signed [CW-1:0] vel,
    input  logic signed [CW-1:0] opos,
    input  logic        [CW-2:0] osize,
    output logic signed [CW+1:0] gap_in,
    output logic signed [CW+1:0] gap_out
);
    localparam int GW = CW + 2;

    logic signed [GW-1:0] pos_far;
    logic signed [GW-1:0] opos_far;
    logic signed [GW-1:0] near_gap;
    logic signed [GW-1:0] far_gap;

    // Edges of both boxes at full width
    assign pos_far  = GW'(pos) + $signed({3'b000, size});
    assign opos_far = GW'(opos) + $signed({3'b000, osize});
    assign near_gap = GW'(opos) - pos_far;
    assign far_gap  = opos_far - GW'(pos);

    // Swap near and far for zero or negative travel
    always_comb begin
        if (vel > 0) begin
            gap_in  = near_gap;
            gap_out = far_gap;
        end else begin
            gap_in  = far_gap;
            gap_out = near_gap;
        end
    end
endmodule

// ----- rtl/sac_div_lane.sv -----
// ----------------------------------------------------------------------------
// sac_div_lane
// Pipelined signed divider: floor(gap * 2^TFB / vel), saturated to +/-2.0.
// One quotient bit per stage; one item may enter every cycle that ld[0] is high.
// ----------------------------------------------------------------------------
module sac_div_lane #(
    parameter int CW  = sac_pkg::CoordWidthDef,
    parameter int TFB = sac_pkg::TimeFracDef
) (
    input  logic                  aclk,
    input  logic [TFB+3:0]        ld,      // per-stage load enables
    input  logic signed [CW+1:0]  gap,
    input  logic signed [CW-1:0]  vel,
    output logic signed [TFB+2:0] quot
);
    localparam int GW = CW + 2;
    localparam int K  = TFB + 2;          // quotient bits
    localparam int TW = TFB + 3;          // signed time width
    localparam logic [K-1:0] Lim = K'(1) << (TFB + 1);

    logic [CW-1:0] rem_reg  [0:K];
    logic [K-1:0]  dvd_reg  [0:K];
    logic [CW-1:0] vm_reg   [0:K];
    logic          neg_reg  [0:K];
    logic          sat_reg  [0:K];
    logic signed [TW-1:0] quot_reg;

    logic [GW-1:0] gap_mag;
    logic [CW-1:0] vel_mag;

    logic [CW:0]   trial    [0:K-1];
    logic [CW-1:0] rem_next [0:K-1];
    logic [K-1:0]  take;

    logic [K:0]           mag_up;
    logic [K-1:0]         mag_cl;
    logic signed [TW-1:0] quot_next;

    // Magnitudes and sign of the quotient
    assign gap_mag = gap[GW-1] ? GW'(-gap) : GW'(gap);
    assign vel_mag = vel[CW-1] ? CW'(-vel) : CW'(vel);

    // Restoring division step for every stage
    always_comb begin
        for (int j = 0; j < K; j++) begin
            trial[j]    = {rem_reg[j], dvd_reg[j][K-1]};
            take[j]     = trial[j] >= {1'b0, vm_reg[j]};
            rem_next[j] = take[j] ? CW'(trial[j] - {1'b0, vm_reg[j]}) : trial[j][CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        // Set up: quotient fits K bits unless the gap is four divisors or more
        if (ld[0]) begin
            rem_reg[0] <= gap_mag[GW-1:2];
            dvd_reg[0] <= {gap_mag[1:0], {TFB{1'b0}}};
            vm_reg[0]  <= vel_mag;
            neg_reg[0] <= gap[GW-1] ^ vel[CW-1];
            sat_reg[0] <= gap_mag >= {vel_mag, 2'b00};
        end
        // Advance one quotient bit per stage
        for (int j = 0; j < K; j++) begin
            if (ld[j+1]) begin
                rem_reg[j+1] <= rem_next[j];
                dvd_reg[j+1] <= {dvd_reg[j][K-2:0], take[j]};
                vm_reg[j+1]  <= vm_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    // Round toward minus infinity, then clamp
    always_comb begin
        mag_up = {1'b0, dvd_reg[K]} + {{K{1'b0}}, |rem_reg[K]};
        if (neg_reg[K]) begin
            mag_cl = (mag_up > {1'b0, Lim}) ? Lim : mag_up[K-1:0];
        end else begin
            mag_cl = (dvd_reg[K] > Lim) ? Lim : dvd_reg[K];
        end
        if (sat_reg[K]) begin
            mag_cl = Lim;
        end
        quot_next = neg_reg[K] ? -$signed({1'b0, mag_cl}) : $signed({1'b0, mag_cl});
    end

    always_ff @(posedge aclk) begin
        if (ld[K+1]) begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
endmodule

// ----- rtl/sac_resolve.sv -----
// ----------------------------------------------------------------------------
// sac_resolve
// Combine the axis times into the hit flag, entry time and surface normal.
// ----------------------------------------------------------------------------
module sac_resolve #(
    parameter int TFB = sac_pkg::TimeFracDef
) (
    input  logic signed [TFB+2:0]  tx_in,
    input  logic signed [TFB+2:0]  tx_out,
    input  logic signed [TFB+2:0]  ty_in,
    input  logic signed [TFB+2:0]  ty_out,
    input  sac_pkg::aux_t          aux,
    output logic                   hit,
    output logic [sac_pkg::EntryWidth-1:0]         entry_time,
    output logic signed [sac_pkg::NormalWidth-1:0] normal_x,
    output logic signed [sac_pkg::NormalWidth-1:0] normal_y
);
    localparam int TW  = TFB + 3;
    localparam int TIW = (TW > sac_pkg::EntryWidth) ? TW : sac_pkg::EntryWidth;
    localparam logic signed [TW-1:0] OneT   = TW'(1) << TFB;
    localparam logic signed [TW-1:0] PosInf = (TW'(1) << (TFB + 1)) + TW'(1);
    localparam logic signed [TW-1:0] NegInf = -PosInf;

    logic signed [TW-1:0]  enx, exx, eny, exy, t_in, t_out;
    logic signed [TIW-1:0] t_ext;
    logic x_first;

    // A still axis never bounds the interval
    assign enx = aux.vel_x_zero ? NegInf : tx_in;
    assign exx = aux.vel_x_zero ? PosInf : tx_out;
    assign eny = aux.vel_y_zero ? NegInf : ty_in;
    assign exy = aux.vel_y_zero ? PosInf : ty_out;

    assign x_first = enx > eny;
    assign t_in    = x_first ? enx : eny;
    assign t_out   = (exx < exy) ? exx : exy;

    assign hit = !((t_in > t_out) || (enx < 0 && eny < 0) || (enx > OneT) || (eny > OneT));

    assign t_ext = hit ? TIW'(t_in) : TIW'(OneT);
    assign entry_time = t_ext[sac_pkg::EntryWidth-1:0];

    // Normal from the later axis, y on a tie
    always_comb begin
        normal_x = sac_pkg::NormalZero;
        normal_y = sac_pkg::NormalZero;
        if (hit) begin
            if (x_first) begin
                normal_x = aux.gap_x_neg ? sac_pkg::NormalPos : sac_pkg::NormalNeg;
            end else begin
                normal_y = aux.gap_y_neg ? sac_pkg::NormalPos : sac_pkg::NormalNeg;
            end
        end
    end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for swept_aabb_collision_time_unit: a directed table of box pairs
// and then random pairs are streamed in, and every result is checked field by
// field against a typed answer or an in-bench predictor of the swept box test.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW        = sac_pkg::CoordWidthDef;
    localparam int TF        = sac_pkg::TimeFracDef;
    localparam int InWidth   = ((10*CW-4+7)/8)*8;
    localparam int LatCycles = TF + 10;
    localparam int WatchMax  = 20000;
    localparam longint OneT  = longint'(1) << TF;
    localparam longint SatHi = 2 * OneT;
    localparam longint SatLo = -2 * OneT;

    typedef struct {
        logic signed [CW-1:0] mover_left;
        logic signed [CW-1:0] mover_top;
        logic [CW-2:0]        mover_width;
        logic [CW-2:0]        mover_height;
        logic signed [CW-1:0] vel_x;
        logic signed [CW-1:0] vel_y;
        logic signed [CW-1:0] obstacle_left;
        logic signed [CW-1:0] obstacle_top;
        logic [CW-2:0]        obstacle_width;
        logic [CW-2:0]        obstacle_height;
    } pair_t;

    typedef struct {
        logic                                     hit;
        logic [sac_pkg::EntryWidth-1:0]           entry_time;
        logic signed [sac_pkg::NormalWidth-1:0]   normal_x;
        logic signed [sac_pkg::NormalWidth-1:0]   normal_y;
    } contact_t;

    typedef struct {
        pair_t    pair;
        bit       typed;
        contact_t want;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic [InWidth-1:0]   s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;

    contact_t contact_q[$];
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       recv_hold;

    swept_aabb_collision_time_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Floor division scaled to time, saturated to [-2.0, +2.0]
    function automatic longint scaled_time(longint gap, longint vel);
        longint n;
        longint q;
        n = gap * OneT;
        q = n / vel;
        if ((n % vel) != 0 && ((n < 0) != (vel < 0)))
            q--;
        if (q > SatHi)
            q = SatHi;
        if (q < SatLo)
            q = SatLo;
        return q;
    endfunction

    // Entry gap and entry/exit times along one axis
    function automatic void sweep_axis(input longint pos, input longint size,
                                       input longint vel, input longint opos,
                                       input longint osize,
                                       output longint gap_in, output longint t_in,
                                       output longint t_out);
        longint gap_out;
        if (vel > 0) begin
            gap_in  = opos - (pos + size);
            gap_out = (opos + osize) - pos;
        end else begin
            gap_in  = (opos + osize) - pos;
            gap_out = opos - (pos + size);
        end
        if (vel == 0) begin
            t_in  = SatLo - 1;
            t_out = SatHi + 1;
        end else begin
            t_in  = scaled_time(gap_in, vel);
            t_out = scaled_time(gap_out, vel);
        end
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        longint gx, gy, enx, eny, exx, exy, t_in, t_out;
        contact_t c;
        sweep_axis(longint'(p.mover_left), longint'(p.mover_width), longint'(p.vel_x),
                   longint'(p.obstacle_left), longint'(p.obstacle_width), gx, enx, exx);
        sweep_axis(longint'(p.mover_top), longint'(p.mover_height), longint'(p.vel_y),
                   longint'(p.obstacle_top), longint'(p.obstacle_height), gy, eny, exy);
        t_in  = enx > eny ? enx : eny;
        t_out = exx < exy ? exx : exy;
        c.hit = !(t_in > t_out || (enx < 0 && eny < 0) || enx > OneT || eny > OneT);
        c.normal_x = sac_pkg::NormalZero;
        c.normal_y = sac_pkg::NormalZero;
        if (c.hit) begin
            if (enx > eny)
                c.normal_x = gx < 0 ? sac_pkg::NormalPos : sac_pkg::NormalNeg;
            else
                c.normal_y = gy < 0 ? sac_pkg::NormalPos : sac_pkg::NormalNeg;
        end else begin
            t_in = OneT;
        end
        c.entry_time = t_in[sac_pkg::EntryWidth-1:0];
        return c;
    endfunction

    function automatic logic [InWidth-1:0] pack_pair(pair_t p);
        return InWidth'({p.obstacle_height, p.obstacle_width, p.obstacle_top,
                         p.obstacle_left, p.vel_y, p.vel_x, p.mover_height,
                         p.mover_width, p.mover_top, p.mover_left});
    endfunction

    function automatic pair_t make_pair(int ml, int mt, int mw, int mh, int vx, int vy,
                                        int ol, int ot, int ow, int oh);
        pair_t p;
        p.mover_left      = CW'(ml);
        p.mover_top       = CW'(mt);
        p.mover_width     = (CW-1)'(mw);
        p.mover_height    = (CW-1)'(mh);
        p.vel_x           = CW'(vx);
        p.vel_y           = CW'(vy);
        p.obstacle_left   = CW'(ol);
        p.obstacle_top    = CW'(ot);
        p.obstacle_width  = (CW-1)'(ow);
        p.obstacle_height = (CW-1)'(oh);
        return p;
    endfunction

    // Random pair: mostly near the obstacle so hits are common
    function automatic pair_t random_pair();
        pair_t p;
        int    span;
        if ($urandom_range(0, 3) == 0) begin
            p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
        end else begin
            span = ($urandom_range(0, 9) == 0) ? 16000 : 800;
            p = make_pair($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                          $urandom_range(0, span), $urandom_range(0, span),
                          $urandom_range(0, 4*span) - 2*span,
                          $urandom_range(0, 4*span) - 2*span,
                          $urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                          $urandom_range(0, span), $urandom_range(0, span));
            if ($urandom_range(0, 9) == 0)
                p.vel_x = '0;
            if ($urandom_range(0, 9) == 0)
                p.vel_y = '0;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Offer one pair and hold it until the transfer
    task automatic send_pair(pair_t p, contact_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata  <= pack_pair(p);
        s_axis_tvalid <= 1'b1;
        contact_q.push_back(want);
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (contact_q.size() != 0)
            @(negedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    initial begin
        int hold_left;
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (recv_hold && hold_left == 0)
                hold_left = 200;
            if (hold_left > 0) begin
                hold_left--;
                recv_hold = 1'b0;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest expectation
    always @(posedge aclk) begin
        contact_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (contact_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = contact_q.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                    report_mismatch("hit", m_axis_tdata[0], want.hit);
                if (m_axis_tdata[16:1] !== want.entry_time)
                    report_mismatch("entry_time", m_axis_tdata[16:1], want.entry_time);
                if (m_axis_tdata[18:17] !== want.normal_x)
                    report_mismatch("normal_x", $signed(m_axis_tdata[18:17]),
                                    want.normal_x);
                if (m_axis_tdata[20:19] !== want.normal_y)
                    report_mismatch("normal_y", $signed(m_axis_tdata[20:19]),
                                    want.normal_y);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchMax) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        row_t     rows[$];
        row_t     r;
        contact_t no_hit;
        contact_t want;
        pair_t    p;
        int       phase;
        errors        = 0;
        idle_cycles   = 0;
        recv_hold     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        no_hit.hit        = 1'b0;
        no_hit.entry_time = sac_pkg::EntryWidth'(OneT);
        no_hit.normal_x   = sac_pkg::NormalZero;
        no_hit.normal_y   = sac_pkg::NormalZero;

        // Table: typed rows where the answer is plain, predicted elsewhere
        r.typed = 1'b1;
        r.want  = no_hit;
        // all zero: both axes stationary, entry below zero on both axes
        r.pair = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        // moving away on both axes
        r.pair = make_pair(0, 0, 16, 16, -16, -16, 100, 100, 16, 16);
        rows.push_back(r);
        // straight hit along x at half step, normal -1
        r.pair = make_pair(0, 0, 16, 16, 64, 0, 48, 0, 16, 16);
        r.want.hit = 1'b1;
        r.want.entry_time = sac_pkg::EntryWidth'(OneT / 2);
        r.want.normal_x = sac_pkg::NormalNeg;
        r.want.normal_y = sac_pkg::NormalZero;
        rows.push_back(r);
        r.typed = 1'b0;
        // extremes of every field
        r.pair = make_pair(-32768, -32768, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767);
        rows.push_back(r);
        r.pair = make_pair(32767, 32767, 0, 0, -32768, -32768,
                           -32768, -32768, 32767, 32767);
        rows.push_back(r);
        r.pair = make_pair(-32768, 32767, 32767, 0, 32767, -32768,
                           32767, -32768, 0, 32767);
        rows.push_back(r);
        r.pair = make_pair(-1, -1, 32767, 32767, -1, -1, -1, -1, 32767, 32767);
        rows.push_back(r);
        // hits with equal entry times (y gives normal), negative then positive displacement
        r.pair = make_pair(64, 64, 16, 16, -64, -64, 0, 0, 32, 32);
        rows.push_back(r);
        r.pair = make_pair(0, 0, 16, 16, 32, 32, 32, 32, 16, 16);
        rows.push_back(r);
        // already overlapping, entry gap negative
        r.pair = make_pair(0, 0, 32, 32, 8, 0, 16, 8, 32, 32);
        rows.push_back(r);
        // entry just above one, just at one
        r.pair = make_pair(0, 0, 16, 16, 63, 0, 80, 0, 16, 16);
        rows.push_back(r);
        r.pair = make_pair(0, 0, 16, 16, 64, 0, 80, 0, 16, 16);
        rows.push_back(r);
        // saturating quotient: tiny displacement, huge gap
        r.pair = make_pair(-30000, 0, 16, 16, 1, 3, 30000, 0, 16, 16);
        rows.push_back(r);
        // stationary y, x hit from the right
        r.pair = make_pair(100, 0, 16, 16, -50, 0, 50, 0, 16, 16);
        rows.push_back(r);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].typed)
                want = rows[i].want;
            else
                want = predict_contact(rows[i].pair);
            send_pair(rows[i].pair, want);
        end

        // Long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        repeat (60) begin
            p = random_pair();
            send_pair(p, predict_contact(p));
        end
        // Pause until everything has drained
        wait_drained();

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 25 : 0;
            repeat (160) begin
                p = random_pair();
                send_pair(p, predict_contact(p));
            end
        end

        wait_drained();
        repeat (LatCycles) @(negedge aclk);
        if (errors == 0 && contact_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
